// File: rtl/quadratic_root_solver_macros.svh
// Assertion macros used by the solver RTL.
`ifndef QUADRATIC_ROOT_SOLVER_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_MACROS_SVH

// Implication checked on every rising clock edge, ignored while reset is held.
`define QRS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that also holds while reset is held.
`define QRS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/qrs_pkg.sv
package qrs_pkg;

    // Default widths of the coefficients and of the root fraction.
    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed widths of the stream fields.
    localparam int FIELD_W  = 16;
    localparam int OUT_W    = 34;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 104;

    // Root classification codes.
    localparam logic [STATUS_W-1:0] ST_TWO    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DOUBLE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ZERO_A = 2'd3;

endpackage

// File: rtl/quadratic_root_solver.sv
// Real roots of a*x^2 + b*x + c for one coefficient set per transaction. The block
// accepts a new set every clock cycle while s_tready is high and returns one result
// transaction for each. The sets pass through a row of square root cells (one per
// root bit) followed by two parallel rows of divider cells (one per quotient bit).
// A two-entry output buffer keeps the input open while a finished result waits;
// s_tready falls only once that buffer is full.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // coef_a [15:0], coef_b [31:16], coef_c [47:32]
    input  logic [qrs_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // first_root [33:0], second_root [67:34], discriminant [101:68],
    // opens_upward [102], zero [103]
    output logic [qrs_pkg::M_DATA_W-1:0]  m_tdata,
    // root_status [1:0]
    output logic [qrs_pkg::STATUS_W-1:0]  m_tuser
);
    import qrs_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int DW  = 2 * W + 2;
    localparam int SW  = W + 1;
    localparam int DVW = W + 1;
    localparam int NB  = W + 1 + FRAC_BITS;
    localparam int QW  = NB + 1;
    localparam int XA  = (QW > DW) ? QW : DW;
    localparam int XW  = ((XA > OUT_W) ? XA : OUT_W) + 1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                up;
        logic signed [DW-1:0] disc;
        logic signed [W-1:0]  b;
    } sq_meta_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                up;
        logic signed [DW-1:0] disc;
        logic                neg1;
        logic                neg2;
    } dv_meta_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                up;
        logic [OUT_W-1:0]    disc;
        logic [OUT_W-1:0]    r1;
        logic [OUT_W-1:0]    r2;
    } res_t;

    logic ce;
    logic signed [W-1:0] a_in, b_in, c_in;

    // Each coefficient is the low COEF_WIDTH bits of its field, zero-extended if wider.
    if (W <= FIELD_W) begin : g_narrow
        assign a_in = s_tdata[W-1:0];
        assign b_in = s_tdata[FIELD_W+W-1:FIELD_W];
        assign c_in = s_tdata[2*FIELD_W+W-1:2*FIELD_W];
    end else begin : g_wide
        assign a_in = W'(s_tdata[FIELD_W-1:0]);
        assign b_in = W'(s_tdata[2*FIELD_W-1:FIELD_W]);
        assign c_in = W'(s_tdata[3*FIELD_W-1:2*FIELD_W]);
    end

    // Stage one: products.
    logic                   v1_reg;
    logic signed [W-1:0]    a1_reg, b1_reg;
    logic signed [2*W-1:0]  bb_reg, ac_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (ce) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            a1_reg <= a_in;
            b1_reg <= b_in;
            bb_reg <= b_in * b_in;
            ac_reg <= a_in * c_in;
        end
    end

    // Stage two: discriminant and classification.
    logic signed [DW-1:0] disc_next;
    logic [STATUS_W-1:0]  status_next;
    logic                 v2_reg;
    sq_meta_t             m2_reg;
    logic signed [W-1:0]  a2_reg;

    always_comb begin
        disc_next = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
        if (a1_reg == '0) begin
            status_next = ST_ZERO_A;
        end else if (disc_next > 0) begin
            status_next = ST_TWO;
        end else if (disc_next == '0) begin
            status_next = ST_DOUBLE;
        end else begin
            status_next = ST_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (ce) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m2_reg.status <= status_next;
            m2_reg.up     <= (a1_reg > 0);
            m2_reg.disc   <= disc_next;
            m2_reg.b      <= b1_reg;
            a2_reg        <= a1_reg;
        end
    end

    // Square root row; the sideband rides beside the cells.
    logic [2*SW-1:0]     sq_rad  [0:SW];
    logic [SW+1:0]       sq_rem  [0:SW];
    logic [SW-1:0]       sq_root [0:SW];
    sq_meta_t            sq_meta [0:SW];
    logic signed [W-1:0] sq_a    [0:SW];
    logic [SW:1]         sq_v_reg;
    logic [SW:0]         sq_v;

    assign sq_rad[0]  = m2_reg.disc[DW-1] ? '0 : (2*SW)'($unsigned(m2_reg.disc));
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;
    assign sq_meta[0] = m2_reg;
    assign sq_a[0]    = a2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_v_reg <= '0;
        end else if (ce) begin
            sq_v_reg <= sq_v[SW-1:0];
        end
    end
    assign sq_v = {sq_v_reg, v2_reg};

    for (genvar k = 0; k < SW; k++) begin : g_sq
        qrs_sqrt_cell #(.SW(SW)) u_cell (
            .aclk     (aclk),
            .ce       (ce),
            .rad_in   (sq_rad[k]),
            .rem_in   (sq_rem[k]),
            .root_in  (sq_root[k]),
            .rad_out  (sq_rad[k+1]),
            .rem_out  (sq_rem[k+1]),
            .root_out (sq_root[k+1])
        );

        sq_meta_t            meta_reg;
        logic signed [W-1:0] a_reg;
        always_ff @(posedge aclk) begin
            if (ce) begin
                meta_reg <= sq_meta[k];
                a_reg    <= sq_a[k];
            end
        end
        assign sq_meta[k+1] = meta_reg;
        assign sq_a[k+1]    = a_reg;
    end

    // Numerators, their magnitudes and the divisor magnitude.
    logic signed [W+1:0] bx, sx, n1, n2;
    logic signed [W:0]   a2x;
    logic [W:0]          n1_mag, n2_mag, den_mag;
    logic                pv_reg;
    dv_meta_t            pm_reg;
    logic [DVW-1:0]      pden_reg;
    logic [NB-1:0]       pn1_reg, pn2_reg;

    always_comb begin
        bx      = (W+2)'(sq_meta[SW].b);
        sx      = $signed({1'b0, sq_root[SW]});
        n1      = -bx - sx;
        n2      = -bx + sx;
        a2x     = {sq_a[SW], 1'b0};
        n1_mag  = n1[W+1] ? (W+1)'(-n1) : n1[W:0];
        n2_mag  = n2[W+1] ? (W+1)'(-n2) : n2[W:0];
        den_mag = a2x[W] ? (-a2x) : a2x;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else if (ce) begin
            pv_reg <= sq_v[SW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            pm_reg.status <= sq_meta[SW].status;
            pm_reg.up     <= sq_meta[SW].up;
            pm_reg.disc   <= sq_meta[SW].disc;
            pm_reg.neg1   <= n1[W+1] ^ sq_a[SW][W-1];
            pm_reg.neg2   <= n2[W+1] ^ sq_a[SW][W-1];
            pden_reg      <= den_mag;
            pn1_reg       <= NB'(n1_mag) << FRAC_BITS;
            pn2_reg       <= NB'(n2_mag) << FRAC_BITS;
        end
    end

    // Two divider rows, one per root, sharing the sideband.
    logic [DVW-1:0] d1_den [0:NB];
    logic [DVW-1:0] d1_rem [0:NB];
    logic [NB-1:0]  d1_nq  [0:NB];
    logic [DVW-1:0] d2_den [0:NB];
    logic [DVW-1:0] d2_rem [0:NB];
    logic [NB-1:0]  d2_nq  [0:NB];
    dv_meta_t       dv_meta [0:NB];
    logic [NB:1]    dv_v_reg;
    logic [NB:0]    dv_v;

    assign d1_den[0]  = pden_reg;
    assign d1_rem[0]  = '0;
    assign d1_nq[0]   = pn1_reg;
    assign d2_den[0]  = pden_reg;
    assign d2_rem[0]  = '0;
    assign d2_nq[0]   = pn2_reg;
    assign dv_meta[0] = pm_reg;
    assign dv_v       = {dv_v_reg, pv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg <= '0;
        end else if (ce) begin
            dv_v_reg <= dv_v[NB-1:0];
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_dv
        qrs_div_cell #(.DVW(DVW), .NB(NB)) u_first (
            .aclk    (aclk),
            .ce      (ce),
            .den_in  (d1_den[k]),
            .rem_in  (d1_rem[k]),
            .nq_in   (d1_nq[k]),
            .den_out (d1_den[k+1]),
            .rem_out (d1_rem[k+1]),
            .nq_out  (d1_nq[k+1])
        );
        qrs_div_cell #(.DVW(DVW), .NB(NB)) u_second (
            .aclk    (aclk),
            .ce      (ce),
            .den_in  (d2_den[k]),
            .rem_in  (d2_rem[k]),
            .nq_in   (d2_nq[k]),
            .den_out (d2_den[k+1]),
            .rem_out (d2_rem[k+1]),
            .nq_out  (d2_nq[k+1])
        );

        dv_meta_t meta_reg;
        always_ff @(posedge aclk) begin
            if (ce) begin
                meta_reg <= dv_meta[k];
            end
        end
        assign dv_meta[k+1] = meta_reg;
    end

    // Saturate a wide signed value to the output range.
    function automatic logic [OUT_W-1:0] sat_out(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = XW'($signed({1'b0, {(OUT_W-1){1'b1}}}));
        lo = XW'($signed({1'b1, {(OUT_W-1){1'b0}}}));
        if (x > hi) begin
            return hi[OUT_W-1:0];
        end else if (x < lo) begin
            return lo[OUT_W-1:0];
        end
        return x[OUT_W-1:0];
    endfunction

    // Signs, saturation and zeroing by classification.
    logic signed [XW-1:0] q1x, q2x;
    res_t                 res_next;
    res_t                 fin_reg;
    logic                 fv_reg;
    dv_meta_t             dm;

    always_comb begin
        dm  = dv_meta[NB];
        q1x = XW'($signed({1'b0, d1_nq[NB]}));
        q2x = XW'($signed({1'b0, d2_nq[NB]}));
        if (dm.neg1) begin
            q1x = -q1x;
        end
        if (dm.neg2) begin
            q2x = -q2x;
        end
        res_next.status = dm.status;
        res_next.up     = dm.up;
        res_next.disc   = sat_out(XW'(dm.disc));
        res_next.r1     = '0;
        res_next.r2     = '0;
        case (dm.status)
            ST_TWO: begin
                res_next.r1 = sat_out(q1x);
                res_next.r2 = sat_out(q2x);
            end
            ST_DOUBLE: begin
                res_next.r1 = sat_out(q1x);
            end
            default: begin
                res_next.r1 = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (ce) begin
            fv_reg <= dv_v[NB];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            fin_reg <= res_next;
        end
    end

    // Output register with one skid entry; the pipeline holds only when the skid is full.
    logic out_valid_reg, skid_valid_reg;
    res_t out_reg, skid_reg;

    assign ce       = !skid_valid_reg;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (ce) begin
            if (fv_reg) begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_reg <= 1'b1;
                end else begin
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end else if (m_tready) begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (fv_reg) begin
                if (!out_valid_reg || m_tready) begin
                    out_reg <= fin_reg;
                end else begin
                    skid_reg <= fin_reg;
                end
            end
        end else if (m_tready) begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.up, out_reg.disc, out_reg.r2, out_reg.r1};

`include "quadratic_root_solver_macros.svh"

    `QRS_ASSERT(a_skid_needs_out, skid_valid_reg |-> out_valid_reg, "skid full while output empty")
    `QRS_ASSERT(a_zero_a_roots, (m_tvalid && m_tuser == ST_ZERO_A) |-> (out_reg.r1 == '0 && out_reg.r2 == '0 && !out_reg.up), "a zero result carries roots")
    `QRS_ASSERT(a_two_disc_pos, (m_tvalid && m_tuser == ST_TWO) |-> ($signed(out_reg.disc) > 0), "two roots without positive discriminant")
endmodule

// File: rtl/qrs_sqrt_cell.sv
module qrs_sqrt_cell #(
    parameter int SW = 17
) (
    input  logic            aclk,
    input  logic            ce,
    input  logic [2*SW-1:0] rad_in,
    input  logic [SW+1:0]   rem_in,
    input  logic [SW-1:0]   root_in,
    output logic [2*SW-1:0] rad_out,
    output logic [SW+1:0]   rem_out,
    output logic [SW-1:0]   root_out
);
    logic [2*SW-1:0] rad_reg, rad_next;
    logic [SW+1:0]   rem_reg, rem_next;
    logic [SW-1:0]   root_reg, root_next;
    logic [SW+1:0]   rem_shift;
    logic [SW+1:0]   trial;
    logic            fits;

    // One restoring square root step: bring down two radicand bits.
    always_comb begin
        rem_shift = {rem_in[SW-1:0], rad_in[2*SW-1:2*SW-2]};
        trial     = {root_in, 2'b01};
        fits      = (rem_shift >= trial);
        rem_next  = fits ? (rem_shift - trial) : rem_shift;
        root_next = {root_in[SW-2:0], fits};
        rad_next  = {rad_in[2*SW-3:0], 2'b00};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rad_out  = rad_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule

// File: rtl/qrs_div_cell.sv
module qrs_div_cell #(
    parameter int DVW = 17,
    parameter int NB  = 33
) (
    input  logic           aclk,
    input  logic           ce,
    input  logic [DVW-1:0] den_in,
    input  logic [DVW-1:0] rem_in,
    input  logic [NB-1:0]  nq_in,
    output logic [DVW-1:0] den_out,
    output logic [DVW-1:0] rem_out,
    output logic [NB-1:0]  nq_out
);
    logic [DVW-1:0] den_reg;
    logic [DVW-1:0] rem_reg, rem_next;
    logic [NB-1:0]  nq_reg, nq_next;
    logic [DVW-1:0] trial;
    logic           fits;

    // One restoring division step; quotient bits shift in as numerator bits leave.
    always_comb begin
        trial    = {rem_in[DVW-2:0], nq_in[NB-1]};
        fits     = (trial >= den_in);
        rem_next = fits ? (trial - den_in) : trial;
        nq_next  = {nq_in[NB-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            den_reg <= den_in;
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    assign den_out = den_reg;
    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;
endmodule

// File: tb/quadratic_root_solver_tb.sv
module quadratic_root_solver_tb;
    import qrs_pkg::*;

    localparam int LATENCY   = 2 * COEF_WIDTH_DEF + FRAC_BITS_DEF + 7;
    localparam int WATCHDOG  = 20000;
    localparam int N_RANDOM  = 1350;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OUT_W-1:0]    first_root;
        logic [OUT_W-1:0]    second_root;
        logic [OUT_W-1:0]    disc;
        logic                upward;
    } roots_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;
        logic signed [FIELD_W-1:0] c;
        logic                      typed;
        roots_t                    want;
    } coef_row_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0] m_tuser;

    roots_t pending_roots[$];
    int     error_count;
    int     idle_cycles;
    int     sent_count;
    int     got_count;
    int     send_idle_pct;
    int     recv_stall_pct;
    bit     stim_done;
    int     status_seen[4];

    quadratic_root_solver i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    // Clock with an 8 unit period.
    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Truncating integer square root, bit by bit.
    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // Limits a value to the signed output field width.
    function automatic logic [OUT_W-1:0] clip_out(longint x);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (OUT_W - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) x = hi;
        if (x < lo) x = lo;
        return x[OUT_W-1:0];
    endfunction

    // Expected result for one coefficient set; division truncates toward zero.
    function automatic roots_t solve_roots(logic signed [FIELD_W-1:0] a,
                                           logic signed [FIELD_W-1:0] b,
                                           logic signed [FIELD_W-1:0] c);
        roots_t r;
        longint la;
        longint lb;
        longint lc;
        longint d;
        longint s;
        longint r1;
        longint r2;
        la = a;
        lb = b;
        lc = c;
        d  = lb * lb - 4 * la * lc;
        r1 = 0;
        r2 = 0;
        if (la == 0) begin
            r.status = ST_ZERO_A;
        end else if (d > 0) begin
            s = root_floor(d);
            r.status = ST_TWO;
            r1 = ((-lb - s) * (longint'(1) << FRAC_BITS_DEF)) / (2 * la);
            r2 = ((-lb + s) * (longint'(1) << FRAC_BITS_DEF)) / (2 * la);
        end else if (d == 0) begin
            r.status = ST_DOUBLE;
            r1 = (-lb * (longint'(1) << FRAC_BITS_DEF)) / (2 * la);
        end else begin
            r.status = ST_NONE;
        end
        r.first_root  = clip_out(r1);
        r.second_root = clip_out(r2);
        r.disc        = clip_out(d);
        r.upward      = (la > 0);
        return r;
    endfunction

    // Sends one coefficient set and queues its expected result; tvalid stays up
    // afterwards so the next set can follow without a gap.
    task automatic send_set(logic signed [FIELD_W-1:0] a, logic signed [FIELD_W-1:0] b,
                            logic signed [FIELD_W-1:0] c, roots_t want);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {c, b, a};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_roots.push_back(want);
        sent_count++;
        @(negedge aclk);
    endtask

    // Random coefficients: mostly small so every root class turns up often.
    function automatic logic signed [FIELD_W-1:0] pick_coef();
        case ($urandom_range(3))
            0:       return FIELD_W'($urandom);
            1:       return FIELD_W'($signed(FIELD_W'($urandom_range(32))) - 16);
            2:       return $urandom_range(1) ? FIELD_W'(16'sh7fff - $urandom_range(3))
                                              : FIELD_W'(16'sh8000 + $urandom_range(3));
            default: return FIELD_W'($signed(FIELD_W'($urandom_range(512))) - 256);
        endcase
    endfunction

    // Receiver stalls at random and checks every result transaction.
    always @(negedge aclk) begin
        m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end

    always @(posedge aclk) begin
        roots_t got;
        roots_t want;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got.status      = m_tuser;
                got.first_root  = m_tdata[33:0];
                got.second_root = m_tdata[67:34];
                got.disc        = m_tdata[101:68];
                got.upward      = m_tdata[102];
                got_count++;
                status_seen[m_tuser]++;
                if (pending_roots.size() == 0) begin
                    $display("%0t: unexpected result status=%0d", $time, m_tuser);
                    error_count++;
                end else begin
                    want = pending_roots.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: root_status expected %0d got %0d",
                                 $time, want.status, got.status);
                        error_count++;
                    end
                    if (got.first_root !== want.first_root) begin
                        $display("%0t: first_root expected %0d got %0d", $time,
                                 $signed(want.first_root), $signed(got.first_root));
                        error_count++;
                    end
                    if (got.second_root !== want.second_root) begin
                        $display("%0t: second_root expected %0d got %0d", $time,
                                 $signed(want.second_root), $signed(got.second_root));
                        error_count++;
                    end
                    if (got.disc !== want.disc) begin
                        $display("%0t: discriminant expected %0d got %0d", $time,
                                 $signed(want.disc), $signed(got.disc));
                        error_count++;
                    end
                    if (got.upward !== want.upward) begin
                        $display("%0t: opens_upward expected %0b got %0b",
                                 $time, want.upward, got.upward);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= WATCHDOG) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
                $display("quadratic_root_solver_tb: errors");
                $finish;
            end
        end
    end

    // Directed table: typed results where they are obvious, predictor elsewhere.
    coef_row_t directed_rows[] = '{
        '{16'sd0, 16'sd5, 16'sd3, 1'b1,
          '{ST_ZERO_A, 34'd0, 34'd0, 34'd25, 1'b0}},
        '{16'sd0, -16'sd32768, 16'sd7, 1'b1,
          '{ST_ZERO_A, 34'd0, 34'd0, 34'd1073741824, 1'b0}},
        '{16'sd0, 16'sd0, 16'sd0, 1'b1,
          '{ST_ZERO_A, 34'd0, 34'd0, 34'd0, 1'b0}},
        '{16'sd1, 16'sd0, 16'sd1, 1'b1,
          '{ST_NONE, 34'd0, 34'd0, -34'sd4, 1'b1}},
        '{16'sd1, 16'sd2, 16'sd1, 1'b1,
          '{ST_DOUBLE, -34'sd65536, 34'd0, 34'd0, 1'b1}},
        '{16'sd1, 16'sd0, -16'sd1, 1'b1,
          '{ST_TWO, -34'sd65536, 34'd65536, 34'd4, 1'b1}},
        '{-16'sd1, 16'sd0, 16'sd1, 1'b0, '0},
        '{16'sd2, 16'sd3, -16'sd5, 1'b0, '0},
        '{-16'sd3, 16'sd7, 16'sd2, 1'b0, '0},
        '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0},
        '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0},
        '{-16'sd32768, 16'sd0, 16'sd32767, 1'b0, '0},
        '{16'sd32767, -16'sd32768, -16'sd32768, 1'b0, '0},
        '{-16'sd32768, -16'sd32768, 16'sd32767, 1'b0, '0},
        '{16'sd1, -16'sd32768, -16'sd32768, 1'b0, '0},
        '{-16'sd1, 16'sd32767, 16'sd32767, 1'b0, '0},
        '{16'sd1, 16'sd0, 16'sd0, 1'b0, '0},
        '{-16'sd1, -16'sd4, -16'sd4, 1'b0, '0},
        '{16'sd3, 16'sd1, -16'sd2, 1'b0, '0},
        '{16'sd1, 16'sd1, 16'sd0, 1'b0, '0}
    };

    initial begin
        roots_t want;
        logic signed [FIELD_W-1:0] a;
        logic signed [FIELD_W-1:0] b;
        logic signed [FIELD_W-1:0] c;
        int wait_cycles;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        error_count    = 0;
        idle_cycles    = 0;
        sent_count     = 0;
        got_count      = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        stim_done      = 1'b0;
        status_seen    = '{0, 0, 0, 0};
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed rows with no idling.
        foreach (directed_rows[i]) begin
            want = directed_rows[i].typed ? directed_rows[i].want
                 : solve_roots(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c);
            send_set(directed_rows[i].a, directed_rows[i].b, directed_rows[i].c, want);
        end

        // Random phases: free running, sender gaps, receiver stalls, both.
        for (int p = 0; p < 4; p++) begin
            case (p)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            for (int n = 0; n < N_RANDOM / 4; n++) begin
                a = pick_coef();
                b = pick_coef();
                c = pick_coef();
                // Perfect squares now and then to hit the double root.
                if ($urandom_range(7) == 0) begin
                    a = FIELD_W'($signed(FIELD_W'($urandom_range(60))) - 30);
                    b = FIELD_W'(2 * a);
                    c = a;
                end
                send_set(a, b, c, solve_roots(a, b, c));
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then give the pipeline its latency before closing.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_cycles = 0;
        while (pending_roots.size() != 0 && wait_cycles < 100 * WATCHDOG) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (LATENCY + 10) @(posedge aclk);
        if (pending_roots.size() != 0) error_count++;
        $display("Sent %0d coefficient sets and checked %0d results.", sent_count, got_count);
        $display("Two roots %0d, double %0d, none %0d, a zero %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (error_count == 0) begin
            $display("quadratic_root_solver_tb: clean");
        end else begin
            $display("quadratic_root_solver_tb: errors");
        end
        $finish;
    end

endmodule
